[design/rbst_pkg.sv]
package rbst_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned HALF_W  = 31;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned FACE_W  = COORD_W + 2;          // centre +/- half
  localparam int unsigned DIFF_W  = FACE_W + 1;           // face - origin
  localparam int unsigned NUM_W   = DIFF_W - 1 + FRAC_W;  // |diff| << 16
  localparam int unsigned Q_W     = NUM_W + 1;            // signed quotient
  localparam int unsigned T_W     = Q_W + 1;              // room for the unbounded marks
  localparam int unsigned DIST_W  = 31;
  localparam int unsigned DIV_LAT = NUM_W + 2;

  localparam logic signed [T_W-1:0] T_UNB = {2'b00, {(T_W-2){1'b1}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [HALF_W-1:0]  half_x;
    logic        [HALF_W-1:0]  half_y;
    logic        [HALF_W-1:0]  half_z;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] entry_dist;
  } out_word_t;

  // per-item flags that travel beside the dividers
  typedef struct packed {
    logic       valid;
    logic [2:0] dir_zero;
    logic [2:0] in_slab;
  } side_t;

endpackage

[design/rbst_if.sv]
interface rbst_in_if;
  logic               valid;
  logic               ready;
  rbst_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbst_out_if;
  logic                valid;
  logic                ready;
  rbst_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/rbst_div.sv]
// Pipelined restoring divider, one quotient bit per stage, truncates toward zero.
module rbst_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rbst_pkg::DIFF_W-1:0]  num,
  input  logic signed [rbst_pkg::COORD_W-1:0] den,
  output logic signed [rbst_pkg::Q_W-1:0]     quot
);

  localparam int unsigned NW = rbst_pkg::NUM_W;
  localparam int unsigned DW = rbst_pkg::COORD_W;

  logic [DW-1:0] rem_r  [0:NW];
  logic [NW-1:0] nq_r   [0:NW];
  logic [DW-1:0] dmag_r [0:NW];
  logic          neg_r  [0:NW];
  logic signed [rbst_pkg::Q_W-1:0] quot_r;

  logic [rbst_pkg::DIFF_W-1:0] num_abs;
  logic [DW:0]                 den_abs;

  always_comb begin
    num_abs = num[rbst_pkg::DIFF_W-1] ? -num : num;
    den_abs = den[DW-1] ? -{den[DW-1], den} : {den[DW-1], den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      nq_r[0]   <= {num_abs[rbst_pkg::DIFF_W-2:0], {rbst_pkg::FRAC_W{1'b0}}};
      dmag_r[0] <= den_abs[DW-1:0];
      neg_r[0]  <= num[rbst_pkg::DIFF_W-1] ^ den[DW-1];
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          qbit;
    always_comb begin
      trial = {rem_r[s], nq_r[s][NW-1]};
      diff  = trial - {1'b0, dmag_r[s]};
      qbit  = !diff[DW];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        nq_r[s+1]   <= {nq_r[s][NW-2:0], qbit};
        dmag_r[s+1] <= dmag_r[s];
        neg_r[s+1]  <= neg_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= neg_r[NW] ? -$signed({1'b0, nq_r[NW]}) : $signed({1'b0, nq_r[NW]});
    end
  end

  assign quot = quot_r;

endmodule

[design/ray_box_slab_test_core.sv]
// Ray against axis-aligned box, slab method, Q16.16 throughout.
// in_ch carries one ray (origin, direction) and one box (centre, half extents)
// per word; out_ch returns one word per input: hit and the entry distance,
// saturated to 0x7FFFFFFF and zero on a miss.
// The pipeline has 58 register stages: 3 front stages, a 52-stage divider,
// 2 compare stages and the output register.
// The depth is set by the six restoring dividers, one quotient bit per stage,
// working in parallel.
// Throughput: one word per cycle while out_ch.ready is high.
// A stall on out_ch freezes the whole pipeline in place; in_ch.ready drops in
// the same cycle, nothing is lost or repeated, and the waiting result stays
// on out_ch until taken.
// Reset (rst_n low, synchronous) clears every valid bit; data registers keep
// their contents and are ignored.
module ray_box_slab_test_core (
  input  logic clk,
  input  logic rst_n,
  rbst_in_if.sink    in_ch,
  rbst_out_if.source out_ch
);

  localparam int unsigned CW = rbst_pkg::COORD_W;
  localparam int unsigned FW = rbst_pkg::FACE_W;
  localparam int unsigned XW = rbst_pkg::DIFF_W;
  localparam int unsigned TW = rbst_pkg::T_W;
  localparam int unsigned DL = rbst_pkg::DIV_LAT;

  logic en;
  logic out_valid_r;
  rbst_pkg::out_word_t out_r;

  assign en          = out_ch.ready || !out_valid_r;
  assign in_ch.ready = en;

  // stage 1: capture
  rbst_pkg::in_word_t in_r;
  logic v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) in_r <= in_ch.data;
  end

  logic signed [CW-1:0] org_a [3];
  logic signed [CW-1:0] dir_a [3];
  logic signed [CW-1:0] ctr_a [3];
  logic [rbst_pkg::HALF_W-1:0] half_a [3];

  always_comb begin
    org_a[0] = in_r.origin_x; org_a[1] = in_r.origin_y; org_a[2] = in_r.origin_z;
    dir_a[0] = in_r.dir_x;    dir_a[1] = in_r.dir_y;    dir_a[2] = in_r.dir_z;
    ctr_a[0] = in_r.center_x; ctr_a[1] = in_r.center_y; ctr_a[2] = in_r.center_z;
    half_a[0] = in_r.half_x;  half_a[1] = in_r.half_y;  half_a[2] = in_r.half_z;
  end

  // stage 2: faces
  logic signed [FW-1:0] lo2_r  [3];
  logic signed [FW-1:0] hi2_r  [3];
  logic signed [CW-1:0] org2_r [3];
  logic signed [CW-1:0] dir2_r [3];
  logic v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  for (genvar a = 0; a < 3; a++) begin : g_face
    always_ff @(posedge clk) begin
      if (en) begin
        lo2_r[a]  <= {{2{ctr_a[a][CW-1]}}, ctr_a[a]} - {3'b000, half_a[a]};
        hi2_r[a]  <= {{2{ctr_a[a][CW-1]}}, ctr_a[a]} + {3'b000, half_a[a]};
        org2_r[a] <= org_a[a];
        dir2_r[a] <= dir_a[a];
      end
    end
  end

  // stage 3: near/far choice and face - origin
  logic signed [XW-1:0] dn3_r  [3];
  logic signed [XW-1:0] df3_r  [3];
  logic signed [CW-1:0] dir3_r [3];
  rbst_pkg::side_t side3;
  logic v3_r;
  logic [2:0] dz3_r, ins3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  for (genvar a = 0; a < 3; a++) begin : g_diff
    logic signed [FW-1:0] near_f, far_f;
    logic signed [XW-1:0] org_x;
    logic                 dpos;
    always_comb begin
      dpos   = !dir2_r[a][CW-1];
      near_f = dpos ? lo2_r[a] : hi2_r[a];
      far_f  = dpos ? hi2_r[a] : lo2_r[a];
      org_x  = {{(XW-CW){org2_r[a][CW-1]}}, org2_r[a]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dn3_r[a]  <= {near_f[FW-1], near_f} - org_x;
        df3_r[a]  <= {far_f[FW-1], far_f} - org_x;
        dir3_r[a] <= dir2_r[a];
        dz3_r[a]  <= (dir2_r[a] == '0);
        ins3_r[a] <= (org_x >= $signed({lo2_r[a][FW-1], lo2_r[a]})) &&
                     (org_x <= $signed({hi2_r[a][FW-1], hi2_r[a]}));
      end
    end
  end

  assign side3 = '{valid: v3_r, dir_zero: dz3_r, in_slab: ins3_r};

  // dividers, flags delayed alongside
  logic signed [rbst_pkg::Q_W-1:0] qn [3];
  logic signed [rbst_pkg::Q_W-1:0] qf [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbst_div u_near (.clk(clk), .en(en), .num(dn3_r[a]), .den(dir3_r[a]), .quot(qn[a]));
    rbst_div u_far  (.clk(clk), .en(en), .num(df3_r[a]), .den(dir3_r[a]), .quot(qf[a]));
  end

  rbst_pkg::side_t side_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) side_r[i].valid <= 1'b0;
    end else if (en) begin
      side_r[0] <= side3;
      for (int i = 1; i < DL; i++) side_r[i] <= side_r[i-1];
    end
  end

  rbst_pkg::side_t sd;
  assign sd = side_r[DL-1];

  // stage 5: first reduction
  logic signed [TW-1:0] tn [3];
  logic signed [TW-1:0] tf [3];

  for (genvar a = 0; a < 3; a++) begin : g_t
    assign tn[a] = sd.dir_zero[a] ? -rbst_pkg::T_UNB : TW'(qn[a]);
    assign tf[a] = sd.dir_zero[a] ?  rbst_pkg::T_UNB : TW'(qf[a]);
  end

  logic signed [TW-1:0] e01_r, x01_r, e2_r, x2_r;
  logic miss5_r, v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= sd.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e01_r   <= (tn[0] > tn[1]) ? tn[0] : tn[1];
      x01_r   <= (tf[0] < tf[1]) ? tf[0] : tf[1];
      e2_r    <= tn[2];
      x2_r    <= tf[2];
      miss5_r <= |(sd.dir_zero & ~sd.in_slab);
    end
  end

  // stage 6: final entry and exit
  logic signed [TW-1:0] entry6_r, exit6_r;
  logic miss6_r, v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      entry6_r <= (e01_r > e2_r) ? e01_r : e2_r;
      exit6_r  <= (x01_r < x2_r) ? x01_r : x2_r;
      miss6_r  <= miss5_r;
    end
  end

  // stage 7: verdict into the output register
  logic hit7;
  logic big7;

  always_comb begin
    hit7 = !miss6_r && !(entry6_r > exit6_r) && !entry6_r[TW-1];
    big7 = |entry6_r[TW-1:rbst_pkg::DIST_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.hit <= hit7;
      if (!hit7)     out_r.entry_dist <= '0;
      else if (big7) out_r.entry_dist <= '1;
      else           out_r.entry_dist <= entry6_r[rbst_pkg::DIST_W-1:0];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // checks
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.hit |-> out_r.entry_dist == '0)
    else $error("miss with nonzero distance");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v6_r) && $stable(v5_r) && $stable(v1_r))
    else $error("pipeline moved during stall");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !v1_r)
    else $error("valid survived reset");

  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 32'h0001_0000;
  localparam int N_RANDOM = 550;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  rbst_in_if  in_if ();
  rbst_out_if out_if ();

  ray_box_slab_test_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  rbst_pkg::in_word_t  ray_queue[$];
  rbst_pkg::out_word_t hit_queue[$];
  int        n_accepted = 0;
  int        n_errors = 0;
  int        snd_idle = 25;
  int        rcv_idle = 88;
  int        hold_left = 0;
  bit        held = 1'b0;

  // slab intersection, exact in 64 bits
  function automatic rbst_pkg::out_word_t slab_hit(rbst_pkg::in_word_t w);
    longint org[3], dir[3], ctr[3], hlf[3];
    longint lo, hi, nf, ff, tn, tf, t_in, t_out;
    bit ok;
    rbst_pkg::out_word_t r;
    org = '{w.origin_x, w.origin_y, w.origin_z};
    dir = '{w.dir_x, w.dir_y, w.dir_z};
    ctr = '{w.center_x, w.center_y, w.center_z};
    hlf = '{longint'(w.half_x), longint'(w.half_y), longint'(w.half_z)};
    t_in = -(longint'(1) <<< 62);
    t_out = longint'(1) <<< 62;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lo = ctr[a] - hlf[a];
      hi = ctr[a] + hlf[a];
      if (dir[a] == 0) begin
        if (org[a] < lo || org[a] > hi) ok = 1'b0;
      end else begin
        nf = (dir[a] > 0) ? lo : hi;
        ff = (dir[a] > 0) ? hi : lo;
        tn = ((nf - org[a]) * 65536) / dir[a];
        tf = ((ff - org[a]) * 65536) / dir[a];
        if (tn > t_in) t_in = tn;
        if (tf < t_out) t_out = tf;
      end
    end
    if (t_in > t_out || t_in < 0) ok = 1'b0;
    r.hit = ok;
    r.entry_dist = !ok ? '0 : (t_in > longint'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF :
                   t_in[rbst_pkg::DIST_W-1:0];
    return r;
  endfunction

  function automatic rbst_pkg::in_word_t ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                             int cx, int cy, int cz, int hx, int hy, int hz);
    rbst_pkg::in_word_t w;
    w = '{ox, oy, oz, dx, dy, dz, cx, cy, cz, hx[30:0], hy[30:0], hz[30:0]};
    return w;
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int small_val(int mag);
    return $urandom_range(0, 2 * mag) - mag;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        hit_queue.push_back(slab_hit(in_if.data));
        n_accepted++;
        if (n_accepted == 200) begin
          snd_idle = 88;
          rcv_idle = 25;
        end else if (n_accepted == 400) begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (ray_queue.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
          in_if.valid <= 1'b1;
          in_if.data <= ray_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once, while words keep coming
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (!held && n_accepted >= 450) begin
      held <= 1'b1;
      hold_left <= 200;
    end
  end

  // monitor
  always @(posedge clk) begin
    rbst_pkg::out_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (hit_queue.size() == 0) begin
          $display("%t: unexpected word hit=%0b dist=%h", $time, out_if.data.hit,
                   out_if.data.entry_dist);
          n_errors++;
        end else begin
          want = hit_queue.pop_front();
          if (want.hit !== out_if.data.hit) begin
            $display("%t: hit expected %0b actual %0b", $time, want.hit, out_if.data.hit);
            n_errors++;
          end
          if (want.entry_dist !== out_if.data.entry_dist) begin
            $display("%t: entry_dist expected %h actual %h", $time, want.entry_dist,
                     out_if.data.entry_dist);
            n_errors++;
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    longint t, c;
    int o[3], d[3], ce[3];
    rbst_pkg::in_word_t w;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;

    // plain hit along +x, and along -x
    ray_queue.push_back(ray(0, 0, 0, ONE, 0, 0, 10*ONE, 0, 0, ONE, ONE, ONE));
    ray_queue.push_back(ray(0, 0, 0, -ONE, 0, 0, -10*ONE, 0, 0, ONE, ONE, ONE));
    // zero direction, origin outside the slab
    ray_queue.push_back(ray(0, 5*ONE, 0, ONE, 0, 0, 10*ONE, 0, 0, ONE, ONE, ONE));
    // zero direction, origin exactly on the face
    ray_queue.push_back(ray(0, ONE, 0, ONE, 0, 0, 10*ONE, 0, 0, ONE, ONE, ONE));
    // all directions zero, origin inside
    ray_queue.push_back(ray(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    // origin inside the box: negative entry
    ray_queue.push_back(ray(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
    // box behind the ray
    ray_queue.push_back(ray(0, 0, 0, ONE, 0, 0, -10*ONE, 0, 0, ONE, ONE, ONE));
    // intervals just touching at a corner
    ray_queue.push_back(ray(0, 0, 0, ONE, ONE, 0, 2*ONE, 4*ONE, 0, ONE, ONE, ONE));
    // intervals disjoint
    ray_queue.push_back(ray(0, 0, 0, ONE, ONE, 0, 2*ONE, 8*ONE, 0, ONE, ONE, ONE));
    // tiny direction, far box: saturates
    ray_queue.push_back(ray(0, 0, 0, 1, 0, 0, 100*ONE, 0, 0, ONE, ONE, ONE));
    // zero-size box hit exactly
    ray_queue.push_back(ray(0, 0, 0, ONE, ONE, ONE, 3*ONE, 3*ONE, 3*ONE, 0, 0, 0));
    // extremes of every field
    ray_queue.push_back(ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    ray_queue.push_back(ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    ray_queue.push_back(ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    ray_queue.push_back(ray(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                            32'h8000_0000, 0, 0, 32'h7FFF_FFFF, ONE, ONE));
    ray_queue.push_back(ray(0, 0, 0, -1, -1, -1, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 1, 1, 1));

    repeat (N_RANDOM) begin
      case ($urandom_range(0, 3))
        0: w = ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: begin
          // box placed on the ray's path, so most of these should hit
          t = $urandom_range(0, 60);
          for (int a = 0; a < 3; a++) begin
            o[a] = small_val(1 << 22);
            d[a] = ($urandom_range(0, 3) == 0) ? 0 : small_val(1 << 18);
            c = longint'(o[a]) + (longint'(d[a]) * t) + small_val(ONE);
            ce[a] = c[31:0];
          end
          w = ray(o[0], o[1], o[2], d[0], d[1], d[2], ce[0], ce[1], ce[2],
                  $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                  $urandom_range(0, 1 << 20));
        end
        2: w = ray(small_val(1 << 20), small_val(1 << 20), small_val(1 << 20),
                   $urandom_range(0, 2) == 0 ? 0 : small_val(1 << 17),
                   $urandom_range(0, 2) == 0 ? 0 : small_val(1 << 17),
                   $urandom_range(0, 2) == 0 ? 0 : small_val(1 << 17),
                   small_val(1 << 20), small_val(1 << 20), small_val(1 << 20),
                   $urandom_range(0, 1 << 19), $urandom_range(0, 1 << 19),
                   $urandom_range(0, 1 << 19));
        default: w = ray(pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                         pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                         pick_edge(), pick_edge());
      endcase
      ray_queue.push_back(w);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (ray_queue.size() == 0 && !in_if.valid);
    wait (hit_queue.size() == 0);
    repeat (100) @(posedge clk);
    if (n_errors == 0 && hit_queue.size() == 0)
      $display("ray_box_slab_test_core regression: pass");
    else
      $display("ray_box_slab_test_core regression: fail");
    $finish;
  end

  initial begin
    #400000;
    $display("ray_box_slab_test_core regression: fail");
    $finish;
  end

endmodule

[files.f]
design/rbst_pkg.sv
design/rbst_if.sv
design/rbst_div.sv
design/ray_box_slab_test_core.sv
tb/sv/testbench.sv
